>>> rtl/fuif_pkg.sv
`timescale 1ns / 1ps

package fuif_pkg;

    // coverage store geometry
    localparam int unsigned WORD_W             = 64;
    localparam int unsigned WORD_SH            = 6;
    localparam int unsigned POS_W              = 20;
    localparam int unsigned POSITION_COUNT_DEF = 1048576;

    typedef struct packed {
        logic [31:0]      gene_id;
        logic [POS_W-1:0] gene_start;
        logic [POS_W-1:0] gene_end;
        logic [31:0]      hit_id;
        logic [31:0]      hit_from;
        logic [31:0]      hit_to;
    } in_item_t;

    typedef struct packed {
        logic [31:0]      out_hit_id;
        logic [31:0]      hit_low;
        logic [31:0]      hit_high;
        logic [31:0]      out_gene_id;
        logic [POS_W-1:0] out_gene_start;
        logic [POS_W-1:0] out_gene_end;
        logic [31:0]      report_count;
    } out_item_t;

    // classified request handed from front to back; positions already clipped
    typedef struct packed {
        logic [31:0]      hit_id;
        logic [31:0]      hit_low;
        logic [31:0]      hit_high;
        logic [31:0]      gene_id;
        logic [POS_W-1:0] gene_start;
        logic [POS_W-1:0] gene_end;
        logic [POS_W-1:0] lo_pos;
        logic [POS_W-1:0] hi_pos;
    } cmd_t;

    typedef enum logic [1:0] {
        BK_CLEAR,
        BK_IDLE,
        BK_SCAN,
        BK_REPORT
    } bk_state_t;

endpackage

>>> rtl/fuif_ram.sv
`timescale 1ns / 1ps

module fuif_ram #(
    parameter int unsigned WIDTH = 64,
    parameter int unsigned DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> rtl/fuif_front.sv
`timescale 1ns / 1ps

module fuif_front import fuif_pkg::*; #(
    parameter int unsigned POSITION_COUNT = POSITION_COUNT_DEF
) (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    output logic     full,
    input  in_item_t item,
    input  logic     clearing,
    output logic     cmd_valid,
    output cmd_t     cmd,
    input  logic     cmd_pop
);

    localparam logic [31:0] LAST_POS = 32'(POSITION_COUNT - 1);

    cmd_t        q_reg [2];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  cnt_reg, cnt_next;
    logic        accept;
    logic        keep;
    cmd_t        new_cmd;

    // classify: order hit coordinates, clip interval ends to the store
    always_comb
    begin
        new_cmd.hit_id     = item.hit_id;
        new_cmd.hit_low    = (item.hit_from < item.hit_to) ? item.hit_from : item.hit_to;
        new_cmd.hit_high   = (item.hit_from < item.hit_to) ? item.hit_to : item.hit_from;
        new_cmd.gene_id    = item.gene_id;
        new_cmd.gene_start = item.gene_start;
        new_cmd.gene_end   = item.gene_end;
        new_cmd.lo_pos     = (32'(item.gene_start) > LAST_POS) ? POS_W'(LAST_POS)
                                                                : item.gene_start;
        new_cmd.hi_pos     = (32'(item.gene_end) > LAST_POS) ? POS_W'(LAST_POS)
                                                              : item.gene_end;
    end

    assign full   = (cnt_reg == 2'd2) || clearing;
    assign accept = push && !full;
    // a reversed interval changes nothing: dropped here
    assign keep   = accept && (item.gene_start <= item.gene_end);

    assign cmd_valid = (cnt_reg != 2'd0);
    assign cmd       = q_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (keep)
        begin
            wr_ptr_next = !wr_ptr_reg;
        end
        if (cmd_pop)
        begin
            rd_ptr_next = !rd_ptr_reg;
        end
        if (keep && !cmd_pop)
        begin
            cnt_next = cnt_reg + 2'd1;
        end
        else if (!keep && cmd_pop)
        begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (keep)
        begin
            q_reg[wr_ptr_reg] <= new_cmd;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd_pop |-> cmd_valid)
        else $error("request taken from empty queue");

    assert property (@(posedge clk) disable iff (!rst_n)
        clearing |-> !accept)
        else $error("item accepted during store clear");

    assert property (@(posedge clk) disable iff (!rst_n)
        (keep && !cmd_pop) |=> (cnt_reg == $past(cnt_reg) + 2'd1))
        else $error("queue fill count lost a request");

endmodule

>>> rtl/fuif_back.sv
`timescale 1ns / 1ps

module fuif_back import fuif_pkg::*; #(
    parameter int unsigned POSITION_COUNT = POSITION_COUNT_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    output logic      clearing,
    input  logic      cmd_valid,
    input  cmd_t      cmd,
    output logic      cmd_pop,
    output logic      empty,
    input  logic      pop,
    output out_item_t result
);

    localparam int unsigned WORDS  = (POSITION_COUNT + WORD_W - 1) / WORD_W;
    localparam int unsigned AW     = $clog2(WORDS);
    localparam int unsigned FULL_W = (AW + WORD_SH > POS_W) ? AW + WORD_SH : POS_W;
    localparam logic [AW-1:0] LAST_WORD = AW'(WORDS - 1);

    bk_state_t        state_reg, state_next;
    cmd_t             cmd_reg, cmd_next;
    logic [AW-1:0]    lo_word_reg, lo_word_next;
    logic [AW-1:0]    hi_word_reg, hi_word_next;
    logic [AW-1:0]    rd_addr_reg, rd_addr_next;
    logic [AW-1:0]    wr_addr_reg, wr_addr_next;
    logic             rd_more_reg, rd_more_next;
    logic             rd_pend_reg, rd_pend_next;
    logic             covered_reg, covered_next;
    logic [31:0]      last_hit_reg, last_hit_next;
    logic             last_valid_reg, last_valid_next;
    logic [31:0]      count_reg, count_next;
    logic             out_valid_reg, out_valid_next;
    out_item_t        out_reg, out_next;

    logic             ram_wr_en, ram_rd_en;
    logic [AW-1:0]    ram_wr_addr;
    logic [WORD_W-1:0] ram_wr_data, ram_rd_data;

    logic [FULL_W-1:0] lo_ext, hi_ext;
    logic [WORD_SH-1:0] lo_off, hi_off;
    logic [WORD_W-1:0] mask;
    logic              emit, out_free, out_load;

    assign lo_ext = FULL_W'(cmd.lo_pos);
    assign hi_ext = FULL_W'(cmd.hi_pos);
    assign lo_off = cmd_reg.lo_pos[WORD_SH-1:0];
    assign hi_off = cmd_reg.hi_pos[WORD_SH-1:0];

    // bits of the interval that fall in the word being written back
    always_comb
    begin
        mask = '1;
        if (wr_addr_reg == lo_word_reg)
        begin
            mask = mask & ({WORD_W{1'b1}} << lo_off);
        end
        if (wr_addr_reg == hi_word_reg)
        begin
            mask = mask & ({WORD_W{1'b1}} >> (~hi_off));
        end
    end

    assign emit     = !covered_reg && (!last_valid_reg || (last_hit_reg != cmd_reg.hit_id));
    assign out_free = !out_valid_reg || pop;

    always_comb
    begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        lo_word_next    = lo_word_reg;
        hi_word_next    = hi_word_reg;
        rd_addr_next    = rd_addr_reg;
        wr_addr_next    = wr_addr_reg;
        rd_more_next    = rd_more_reg;
        rd_pend_next    = 1'b0;
        covered_next    = covered_reg;
        last_hit_next   = last_hit_reg;
        last_valid_next = last_valid_reg;
        count_next      = count_reg;
        out_next        = out_reg;
        out_valid_next  = out_valid_reg && !pop;
        cmd_pop         = 1'b0;
        ram_wr_en       = 1'b0;
        ram_wr_addr     = wr_addr_reg;
        ram_wr_data     = ram_rd_data | mask;
        ram_rd_en       = 1'b0;
        out_load        = 1'b0;

        unique case (state_reg)
            BK_CLEAR:
            begin
                ram_wr_en    = 1'b1;
                ram_wr_addr  = rd_addr_reg;
                ram_wr_data  = '0;
                rd_addr_next = rd_addr_reg + 1'b1;
                if (rd_addr_reg == LAST_WORD)
                begin
                    state_next = BK_IDLE;
                end
            end
            BK_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_pop      = 1'b1;
                    cmd_next     = cmd;
                    lo_word_next = AW'(lo_ext >> WORD_SH);
                    hi_word_next = AW'(hi_ext >> WORD_SH);
                    rd_addr_next = AW'(lo_ext >> WORD_SH);
                    rd_more_next = 1'b1;
                    covered_next = 1'b0;
                    state_next   = BK_SCAN;
                end
            end
            BK_SCAN:
            begin
                // read word k while word k-1 is tested and written back
                if (rd_more_reg)
                begin
                    ram_rd_en    = 1'b1;
                    rd_pend_next = 1'b1;
                    wr_addr_next = rd_addr_reg;
                    if (rd_addr_reg == hi_word_reg)
                    begin
                        rd_more_next = 1'b0;
                    end
                    else
                    begin
                        rd_addr_next = rd_addr_reg + 1'b1;
                    end
                end
                if (rd_pend_reg)
                begin
                    ram_wr_en    = 1'b1;
                    covered_next = covered_reg || ((ram_rd_data & mask) != '0);
                end
                if (!rd_more_reg && !rd_pend_reg)
                begin
                    state_next = BK_REPORT;
                end
            end
            BK_REPORT:
            begin
                if (!emit)
                begin
                    state_next = BK_IDLE;
                end
                else if (out_free)
                begin
                    out_load                = 1'b1;
                    count_next              = count_reg + 32'd1;
                    last_hit_next           = cmd_reg.hit_id;
                    last_valid_next         = 1'b1;
                    out_valid_next          = 1'b1;
                    out_next.out_hit_id     = cmd_reg.hit_id;
                    out_next.hit_low        = cmd_reg.hit_low;
                    out_next.hit_high       = cmd_reg.hit_high;
                    out_next.out_gene_id    = cmd_reg.gene_id;
                    out_next.out_gene_start = cmd_reg.gene_start;
                    out_next.out_gene_end   = cmd_reg.gene_end;
                    out_next.report_count   = count_reg + 32'd1;
                    state_next              = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= BK_CLEAR;
            rd_addr_reg    <= '0;
            rd_more_reg    <= 1'b0;
            rd_pend_reg    <= 1'b0;
            last_hit_reg   <= '0;
            last_valid_reg <= 1'b0;
            count_reg      <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            rd_addr_reg    <= rd_addr_next;
            rd_more_reg    <= rd_more_next;
            rd_pend_reg    <= rd_pend_next;
            last_hit_reg   <= last_hit_next;
            last_valid_reg <= last_valid_next;
            count_reg      <= count_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg     <= cmd_next;
        lo_word_reg <= lo_word_next;
        hi_word_reg <= hi_word_next;
        wr_addr_reg <= wr_addr_next;
        covered_reg <= covered_next;
        out_reg     <= out_next;
    end

    fuif_ram #(
        .WIDTH (WORD_W),
        .DEPTH (WORDS)
    ) u_map (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (rd_addr_reg),
        .rd_data (ram_rd_data)
    );

    assign clearing = (state_reg == BK_CLEAR);
    assign empty    = !out_valid_reg;
    assign result   = out_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        ram_wr_en |-> (state_reg == BK_SCAN || state_reg == BK_CLEAR))
        else $error("map written outside scan or clear");

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd_pop |-> (state_reg == BK_IDLE))
        else $error("request taken while busy");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> (count_reg == $past(count_reg) + 32'd1) && !empty)
        else $error("report count or result slot out of step");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == BK_SCAN && !rd_more_reg && !rd_pend_reg) |=> (state_reg == BK_REPORT))
        else $error("scan did not close");

endmodule

>>> rtl/first_uncovered_interval_filter_core.sv
`timescale 1ns / 1ps

// Channel   Handshake          Payload     Request accepted when
// -------   ----------------   ---------   ------------------------------
// item      push / full        in_item_t   push && !full at rising clk
// result    empty / pop        out_item_t  pop && !empty at rising clk
//
// Scan: the back end reads, tests and writes back the N 64-position words of
//   the coverage map that an interval spans (read/modify/write pipelined over
//   one single-port-write, single-port-read RAM); reversed ones skip it.
// Reset: rst_n clears control state, then a clearing pass writes every map
//   word, ceil(POSITION_COUNT / 64) of them, with full held high throughout.
// Stalls: a two-request queue parts front and back; a held result only stalls
//   the back end when a further result is ready to be reported.

module first_uncovered_interval_filter_core import fuif_pkg::*; #(
    parameter int unsigned POSITION_COUNT = POSITION_COUNT_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    output logic      full,
    input  in_item_t  item,
    output logic      empty,
    input  logic      pop,
    output out_item_t result
);

    logic clearing;
    logic cmd_valid;
    logic cmd_pop;
    cmd_t cmd;

    // front: accept, drop reversed intervals, order hit, clip ends
    fuif_front #(
        .POSITION_COUNT (POSITION_COUNT)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .item      (item),
        .clearing  (clearing),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop)
    );

    // back: scan and mark the map word by word, then report
    fuif_back #(
        .POSITION_COUNT (POSITION_COUNT)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .clearing  (clearing),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop),
        .empty     (empty),
        .pop       (pop),
        .result    (result)
    );

endmodule
